### src/bsp3_pkg.sv
`default_nettype none
package bsp3_pkg;

  localparam int MAX_BLOCK_COLS_DEF = 256;
  localparam int SAMPLE_BITS_DEF    = 16;

  localparam int SUM_W    = 20;
  localparam int BROW_W   = 11;
  localparam int BCOL_W   = 8;
  localparam int ROWS_W   = 13;
  localparam int COLS_W   = 10;
  localparam int ROWPOS_W = 12;

  localparam int ROW_LIMIT = 4096;
  localparam int COL_LIMIT = 768;

  // register index, taken from paddr[2]
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // one band update, issued at the end of a row segment
  typedef struct packed {
    logic              emit;
    logic              last;
    logic [1:0]        rr;
    logic [BROW_W-1:0] brow;
    logic [BCOL_W-1:0] bcol;
    logic [SUM_W-1:0]  seg;
  } band_op_t;

  typedef struct packed {
    logic [SUM_W-1:0]  block_sum;
    logic [BROW_W-1:0] block_row;
    logic [BCOL_W-1:0] block_col;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

### src/bsp3_band.sv
`default_nettype none
module bsp3_band
  import bsp3_pkg::*;
#(
  parameter int MAX_BLOCK_COLS = MAX_BLOCK_COLS_DEF,
  parameter int AW = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          op_valid,
  input  wire band_op_t      op,
  input  wire logic [AW-1:0] op_addr,
  output logic               res_valid,
  output result_t            res
);

  logic [SUM_W-1:0] band_mem [MAX_BLOCK_COLS];

  logic             s1_v_r;
  band_op_t         s1_op_r;
  logic [AW-1:0]    s1_addr_r;
  logic [SUM_W-1:0] rd_r;
  logic             fwd_r;
  logic [SUM_W-1:0] fwd_data_r;

  logic [SUM_W-1:0] prev;
  logic [SUM_W-1:0] band_nxt;
  logic [SUM_W-1:0] pad_v;

  // read issued with the op; the entry being written this cycle is forwarded
  always_ff @(posedge clk) begin
    if (op_valid) begin
      rd_r <= band_mem[op_addr];
    end
    if (s1_v_r) begin
      band_mem[s1_addr_r] <= band_nxt;
    end
    s1_op_r    <= op;
    s1_addr_r  <= op_addr;
    fwd_r      <= s1_v_r && (s1_addr_r == op_addr);
    fwd_data_r <= band_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= op_valid;
    end
  end

  always_comb begin
    prev = fwd_r ? fwd_data_r : rd_r;
    if (s1_op_r.rr == 2'd0) begin
      band_nxt = s1_op_r.seg;
    end else begin
      band_nxt = prev + s1_op_r.seg;
    end
    // padding rows below the last real row of the band
    case (s1_op_r.rr)
      2'd0:    pad_v = SUM_W'(6);
      2'd1:    pad_v = SUM_W'(3);
      default: pad_v = '0;
    endcase
  end

  assign res_valid     = s1_v_r && s1_op_r.emit;
  assign res.block_sum = band_nxt + pad_v;
  assign res.block_row = s1_op_r.brow;
  assign res.block_col = s1_op_r.bcol;
  assign res.last      = s1_op_r.last;

endmodule
`default_nettype wire

### src/block_sum_pool_3x3_top.sv
// A block's result is registered in the band stage, then written into the result queue, and is offered from there.
// Throughput: one sample per cycle while in_stall is low; the band memory gets one read-modify-write per row segment.
// Results leave through a three-entry queue; input stalls when queued results plus the one in the band stage fill it.
// Reset (synchronous, rst_n low): positions and sums cleared, row_count and col_count = 3.
// The band memory is not cleared; each band's first row writes its entries without using the value read.
`default_nettype none
module block_sum_pool_3x3_top
  import bsp3_pkg::*;
#(
  parameter int MAX_BLOCK_COLS = MAX_BLOCK_COLS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [SUM_W-1:0]            out_block_sum,
  output logic [BROW_W-1:0]           out_block_row,
  output logic [BCOL_W-1:0]           out_block_col,
  output logic                        out_last,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int AW      = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
  localparam int COL_LIM = (3 * MAX_BLOCK_COLS < COL_LIMIT) ? 3 * MAX_BLOCK_COLS : COL_LIMIT;
  localparam int QD      = 3;

  // configuration
  logic [ROWS_W-1:0] row_count_r;
  logic [COLS_W-1:0] col_count_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROWS_W'(3);
      col_count_r <= COLS_W'(3);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ROW_COUNT: row_count_r <= pwdata[ROWS_W-1:0];
        REG_COL_COUNT: col_count_r <= pwdata[COLS_W-1:0];
        default:       row_count_r <= row_count_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROW_COUNT: prdata = 32'(row_count_r);
      REG_COL_COUNT: prdata = 32'(col_count_r);
      default:       prdata = '0;
    endcase
  end

  // clamped matrix size
  logic [ROWS_W-1:0] rows_eff, rows_m1;
  logic [COLS_W-1:0] cols_eff, cols_m1;

  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (row_count_r > ROWS_W'(ROW_LIMIT)) begin
      rows_eff = ROWS_W'(ROW_LIMIT);
    end else begin
      rows_eff = row_count_r;
    end
    if (col_count_r == '0) begin
      cols_eff = COLS_W'(1);
    end else if (col_count_r > COLS_W'(COL_LIM)) begin
      cols_eff = COLS_W'(COL_LIM);
    end else begin
      cols_eff = col_count_r;
    end
    rows_m1 = rows_eff - ROWS_W'(1);
    cols_m1 = cols_eff - COLS_W'(1);
  end

  // raster position counters, with the mod-3 phases and block indices kept alongside
  logic [COLS_W-1:0]   col_r;
  logic [1:0]          cr_r;
  logic [BCOL_W-1:0]   bc_r;
  logic [ROWPOS_W-1:0] row_r;
  logic [1:0]          rr_r;
  logic [BROW_W-1:0]   brow_r;
  logic [SUM_W-1:0]    hsum_r;

  logic             accept;
  logic             col_end, row_end, seg_end, emit;
  logic [31:0]      s_wide;
  logic [SUM_W-1:0] s_ext;
  logic [SUM_W-1:0] seg;
  band_op_t         op;

  assign accept  = in_valid && !in_stall;
  assign col_end = (col_r == cols_m1);
  assign row_end = (row_r == rows_m1[ROWPOS_W-1:0]);
  assign seg_end = (cr_r == 2'd2) || col_end;
  assign emit    = seg_end && ((rr_r == 2'd2) || row_end);

  always_comb begin
    s_wide = 32'(signed'(in_sample));
    s_ext  = s_wide[SUM_W-1:0];
    // padding cells to the right of a short segment count as 1 each
    seg    = hsum_r + s_ext + SUM_W'(2'd2 - cr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      col_r  <= '0;
      cr_r   <= '0;
      bc_r   <= '0;
      row_r  <= '0;
      rr_r   <= '0;
      brow_r <= '0;
      hsum_r <= '0;
    end else if (accept) begin
      hsum_r <= seg_end ? '0 : hsum_r + s_ext;
      if (col_end) begin
        col_r <= '0;
        cr_r  <= '0;
        bc_r  <= '0;
        if (row_end) begin
          row_r  <= '0;
          rr_r   <= '0;
          brow_r <= '0;
        end else begin
          row_r <= row_r + ROWPOS_W'(1);
          if (rr_r == 2'd2) begin
            rr_r   <= '0;
            brow_r <= brow_r + BROW_W'(1);
          end else begin
            rr_r <= rr_r + 2'd1;
          end
        end
      end else begin
        col_r <= col_r + COLS_W'(1);
        if (cr_r == 2'd2) begin
          cr_r <= '0;
          bc_r <= bc_r + BCOL_W'(1);
        end else begin
          cr_r <= cr_r + 2'd1;
        end
      end
    end
  end

  always_comb begin
    op.emit = emit;
    op.last = row_end && col_end;
    op.rr   = rr_r;
    op.brow = brow_r;
    op.bcol = bc_r;
    op.seg  = seg;
  end

  logic    res_valid;
  result_t res;

  bsp3_band #(
    .MAX_BLOCK_COLS (MAX_BLOCK_COLS),
    .AW             (AW)
  ) u_band (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (accept && seg_end),
    .op        (op),
    .op_addr   (AW'(bc_r)),
    .res_valid (res_valid),
    .res       (res)
  );

  // result queue; room is reserved for the result still in the band stage
  result_t     q_mem [QD];
  logic [1:0]  q_wp_r, q_rp_r, q_cnt_r;
  logic        pend_r;
  logic        pop;
  result_t     head;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (q_cnt_r != 2'd0);
  assign in_stall  = (3'(q_cnt_r) + 3'(pend_r)) > 3'(QD - 1);
  assign head      = q_mem[q_rp_r];

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q_mem[q_wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= accept && emit;
      if (res_valid) begin
        q_wp_r <= (q_wp_r == 2'(QD - 1)) ? 2'd0 : q_wp_r + 2'd1;
      end
      if (pop) begin
        q_rp_r <= (q_rp_r == 2'(QD - 1)) ? 2'd0 : q_rp_r + 2'd1;
      end
      if (res_valid && !pop) begin
        q_cnt_r <= q_cnt_r + 2'd1;
      end else if (pop && !res_valid) begin
        q_cnt_r <= q_cnt_r - 2'd1;
      end
    end
  end

  assign out_block_sum = head.block_sum;
  assign out_block_row = head.block_row;
  assign out_block_col = head.block_col;
  assign out_last      = head.last;

endmodule
`default_nettype wire
